// ===== src/assert_macros.svh =====
// assertion helpers included by the rtc_serial_command_engine rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== src/rsce_pkg.sv =====
package rsce_pkg;

   // item kinds
   localparam logic KindTick  = 1'b0;
   localparam logic KindStart = 1'b1;

   // command decoding
   localparam logic [15:0] CmdHighMask   = 16'hFF00;
   localparam logic [15:0] ExtReadFlag   = 16'h8000;
   localparam logic [7:0]  ShortReadFlag = 8'h80;

   // bit counts for the send and receive registers
   localparam logic [4:0] SendOneByte    = 5'd8;
   localparam logic [4:0] SendTwoBytes   = 5'd16;
   localparam logic [4:0] SendThreeBytes = 5'd24;
   localparam logic [3:0] ReceiveBits    = 4'd8;

   typedef struct packed {
      logic        kind;
      logic [15:0] command;
      logic [7:0]  write_byte;
      logic        data_in;
   } item_type;

   typedef struct packed {
      logic       clock_line;
      logic       data_out;
      logic       data_drive;
      logic       enable_n;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       was_read;
   } result_type;

   typedef struct packed {
      logic        active;
      logic        half_phase;
      logic [23:0] send_shift;
      logic [4:0]  send_left;
      logic [7:0]  receive_shift;
      logic [3:0]  receive_left;
      logic        read_mode;
   } link_state_type;

   typedef struct packed {
      link_state_type next_state;
      result_type     result;
      logic           emit;
   } step_type;

endpackage

// ===== src/rtc_serial_command_engine.sv =====
// Three-wire serial clock-chip link master stepped by half-bit tick words.
// A start word (ignored and answered with no word while a command runs) loads
// one or two command bytes and, for a write, the data byte; a read then clocks
// in eight bits. Every word passes an input register and one combinational
// step into the result register, so one word is taken per cycle unless the
// outputs stall; a result stays on the outputs until it is taken at an edge
// where rsp_ready is high; while a result waits the step stalls and the
// input register holds one more word.
`include "assert_macros.svh"

module rtc_serial_command_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [15:0] req_command,
   input  logic [7:0]  req_write_byte,
   input  logic        req_data_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_clock_line,
   output logic        rsp_data_out,
   output logic        rsp_data_drive,
   output logic        rsp_enable_n,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_was_read
);
   import rsce_pkg::*;

   item_type       item_ff;
   logic           item_valid_ff;
   logic           item_valid_in;
   link_state_type state_ff;
   result_type     result_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   step_type       step;
   logic           advance;
   logic           req_take;

   rsce_step u_step (
      .item (item_ff),
      .cur  (state_ff),
      .step (step)
   );

   // handshake control
   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (req_take) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance && step.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (advance) begin
            state_ff <= step.next_state;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= '{kind: req_kind, command: req_command,
                      write_byte: req_write_byte, data_in: req_data_in};
      end
      if (advance && step.emit) begin
         result_ff <= step.result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_clock_line = result_ff.clock_line;
   assign rsp_data_out   = result_ff.data_out;
   assign rsp_data_drive = result_ff.data_drive;
   assign rsp_enable_n   = result_ff.enable_n;
   assign rsp_busy_res   = result_ff.busy_res;
   assign rsp_done_res   = result_ff.done_res;
   assign rsp_read_byte  = result_ff.read_byte;
   assign rsp_was_read   = result_ff.was_read;

   // idle link holds no pending bits
   `ASSERT_IMPLIES(a_idle_counts_clear, clock, reset, !state_ff.active,
      (state_ff.send_left == 5'd0) && (state_ff.receive_left == 4'd0))
   // half phase only inside a command
   `ASSERT_IMPLIES(a_phase_needs_active, clock, reset, state_ff.half_phase,
      state_ff.active)
   // receive bits only for reads
   `ASSERT_IMPLIES(a_receive_only_read, clock, reset, !state_ff.read_mode,
      state_ff.receive_left == 4'd0)
   // a done word always releases the link
   `ASSERT_IMPLIES(a_done_releases, clock, reset, rsp_valid_ff && result_ff.done_res,
      result_ff.enable_n && !result_ff.busy_res)

endmodule

// ===== src/rsce_step.sv =====
module rsce_step (
   input  rsce_pkg::item_type       item,
   input  rsce_pkg::link_state_type cur,
   output rsce_pkg::step_type       step
);
   import rsce_pkg::*;

   logic send_bit;
   logic rd_ext;
   logic rd_short;

   assign send_bit = cur.send_shift[23];
   assign rd_ext   = (item.command & ExtReadFlag) != 16'h0000;
   assign rd_short = (item.command[7:0] & ShortReadFlag) != 8'h00;

   // one tick of the link sequencer
   always_comb begin
      step.next_state = cur;
      step.emit       = 1'b1;
      step.result     = '{clock_line: 1'b1, data_out: 1'b0, data_drive: 1'b1,
                          enable_n: 1'b1, busy_res: 1'b0, done_res: 1'b0,
                          read_byte: 8'h00, was_read: 1'b0};
      if (item.kind == KindStart) begin
         if (cur.active) begin
            // start while busy is dropped without a word
            step.emit = 1'b0;
         end else begin
            if ((item.command & CmdHighMask) != 16'h0000) begin
               step.next_state.send_shift = {item.command[15:8], item.command[7:0],
                                             rd_ext ? 8'h00 : item.write_byte};
               step.next_state.send_left  = rd_ext ? SendTwoBytes : SendThreeBytes;
               step.next_state.read_mode  = rd_ext;
            end else begin
               step.next_state.send_shift = {item.command[7:0],
                                             rd_short ? 8'h00 : item.write_byte, 8'h00};
               step.next_state.send_left  = rd_short ? SendOneByte : SendTwoBytes;
               step.next_state.read_mode  = rd_short;
            end
            step.next_state.receive_shift = 8'h00;
            step.next_state.receive_left  =
               step.next_state.read_mode ? ReceiveBits : 4'd0;
            step.next_state.half_phase    = 1'b0;
            step.next_state.active        = 1'b1;
            step.result.enable_n = 1'b0;
            step.result.busy_res = 1'b1;
         end
      end else if (!cur.active) begin
         // idle lines, defaults apply
         step.result.enable_n = 1'b1;
      end else if (cur.send_left != 5'd0) begin
         // shift out, msb first
         step.result.data_out = send_bit;
         step.result.enable_n = 1'b0;
         step.result.busy_res = 1'b1;
         if (!cur.half_phase) begin
            step.next_state.half_phase = 1'b1;
            step.result.clock_line     = 1'b0;
         end else begin
            step.next_state.half_phase = 1'b0;
            step.next_state.send_shift = {cur.send_shift[22:0], 1'b0};
            step.next_state.send_left  = cur.send_left - 5'd1;
         end
      end else if (cur.receive_left != 4'd0) begin
         // shift in, sampled on the clock-high tick
         step.result.data_drive = 1'b0;
         step.result.enable_n   = 1'b0;
         step.result.busy_res   = 1'b1;
         if (!cur.half_phase) begin
            step.next_state.half_phase = 1'b1;
            step.result.clock_line     = 1'b0;
         end else begin
            step.next_state.half_phase    = 1'b0;
            step.next_state.receive_shift = {cur.receive_shift[6:0], item.data_in};
            step.next_state.receive_left  = cur.receive_left - 4'd1;
         end
      end else begin
         // final tick releases enable and reports
         step.next_state.active     = 1'b0;
         step.next_state.half_phase = 1'b0;
         step.result.done_res  = 1'b1;
         step.result.read_byte = cur.read_mode ? cur.receive_shift : 8'h00;
         step.result.was_read  = cur.read_mode;
      end
   end

endmodule
